@@ hw/rtl/lfbe_pkg.sv @@
// Shared types and constants for the log-frequency breakpoint envelope.
// No dependencies.
package lfbe_pkg;

  localparam int MaxPoints   = 16;
  localparam int MaxHalfSize = 4096;
  localparam int PtAW        = $clog2(MaxPoints);
  localparam int CntW        = $clog2(MaxPoints + 1);

  localparam int FreqW = 24;
  localparam int GainW = 24;
  localparam int LogW  = 21;  // 5 integer bits + 16 fraction bits

  localparam logic [1:0] CmdClear  = 2'd0;
  localparam logic [1:0] CmdAppend = 2'd1;
  localparam logic [1:0] CmdEval   = 2'd2;
  localparam logic [1:0] CmdNone   = 2'd3;  // unused, ignored

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StNotInc  = 3'd1;
  localparam logic [2:0] StFull    = 3'd2;
  localparam logic [2:0] StZero    = 3'd3;
  localparam logic [2:0] StEmpty   = 3'd4;

  localparam logic [0:0] RegHalfSize = 1'd0;
  localparam logic [0:0] RegBinHop   = 1'd1;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input transaction
    logic scan;       // take contour entry read at rd_idx
    logic wr;         // write contour entry
    logic log_step;   // take log of bin frequency
    logic div_start;
    logic div_step;
    logic prod;       // fraction times gain delta
    logic fin;        // build result
    logic [2:0] fin_sel;
  } lfbe_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic below;      // read entry frequency < bin frequency
    logic not_above;  // input frequency <= last stored
    logic freq_zero;  // input frequency is zero
  } lfbe_stat_t;

  localparam logic [2:0] FinZero  = 3'd0;
  localparam logic [2:0] FinFirst = 3'd1;
  localparam logic [2:0] FinLast  = 3'd2;
  localparam logic [2:0] FinInterp = 3'd3;

  // Mitchell log2, Q5.16
  function automatic logic [LogW-1:0] mlog2(input logic [FreqW-1:0] x);
    logic [4:0] k;
    logic [FreqW+15:0] f;
    k = '0;
    for (int i = 0; i < FreqW; i++)
      if (x[i]) k = 5'(i);
    f = ({16'd0, x} ^ ({{(FreqW+15){1'b0}}, 1'b1} << k)) << 16;
    f = f >> k;
    mlog2 = {k, f[15:0]};
  endfunction

endpackage

@@ hw/rtl/lfbe_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module lfbe_ram #(
  parameter int Width = 24,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

@@ hw/rtl/lfbe_datapath.sv @@
// Datapath: contour memories, bin frequency, logs, serial divider, product.
// Depends on lfbe_pkg and lfbe_ram.
module lfbe_datapath
  import lfbe_pkg::*;
(
  input  logic             clk,
  input  lfbe_cmd_t        cmd,
  input  logic [PtAW-1:0]  rd_idx,
  input  logic [FreqW-1:0] in_freq,
  input  logic [GainW-1:0] in_gain,
  input  logic [12:0]      in_bin,
  input  logic [19:0]      bin_hop,
  output lfbe_stat_t       stat,
  output logic [GainW-1:0] value
);
  logic [FreqW-1:0] freq_r, ffreq_r, frd;
  logic [GainW-1:0] gain_r, grd, g1_r, g2_r;
  logic [FreqW-1:0] binf_r;
  logic [LogW-1:0]  lo_r, hi_r, x_r;
  logic [LogW:0]    rem_r, dvs, rem_diff;
  logic [16:0]      q_r;
  logic             dz_r;
  logic [15:0]      frac;
  logic signed [24:0] gdiff;
  logic signed [41:0] prod_r;
  logic [GainW-1:0] value_r;
  logic [32:0]      f64;

  lfbe_ram #(.Width(FreqW), .Depth(MaxPoints)) u_freq (
    .clk(clk), .we(cmd.wr), .addr(rd_idx), .wdata(freq_r), .rdata(frd));
  lfbe_ram #(.Width(GainW), .Depth(MaxPoints)) u_gain (
    .clk(clk), .we(cmd.wr), .addr(rd_idx), .wdata(gain_r), .rdata(grd));

  assign f64 = 33'(in_bin) * 33'(bin_hop);
  assign dvs = {1'b0, hi_r - lo_r};
  assign rem_diff = rem_r - dvs;
  // no interpolation fraction when the logs do not order
  assign frac = dz_r ? 16'd0 : (q_r[16] ? 16'hFFFF : q_r[15:0]);
  assign gdiff = $signed({g2_r[GainW-1], g2_r}) - $signed({g1_r[GainW-1], g1_r});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      freq_r <= in_freq;
      gain_r <= in_gain;
      binf_r <= (|f64[32:24]) ? {FreqW{1'b1}} : f64[23:0];
    end
    if (cmd.scan) begin
      ffreq_r <= frd;
      g1_r    <= g2_r;
      g2_r    <= grd;
      hi_r    <= mlog2(frd);
      lo_r    <= hi_r;
    end
    if (cmd.log_step) x_r <= mlog2(binf_r);
    if (cmd.div_start) begin
      dz_r  <= !(hi_r > lo_r && x_r > lo_r);
      rem_r <= {1'b0, x_r - lo_r};
      q_r   <= '0;
    end else if (cmd.div_step) begin
      // restoring fractional division, quotient bit 16 first
      if (rem_r >= dvs) begin
        rem_r <= {rem_diff[LogW-1:0], 1'b0};
        q_r   <= {q_r[15:0], 1'b1};
      end else begin
        rem_r <= {rem_r[LogW-1:0], 1'b0};
        q_r   <= {q_r[15:0], 1'b0};
      end
    end
    if (cmd.prod)
      prod_r <= $signed({1'b0, frac}) * gdiff;
    if (cmd.fin) begin
      case (cmd.fin_sel)
        FinFirst:  value_r <= g2_r;
        FinLast:   value_r <= g2_r;
        FinInterp: value_r <= g1_r + prod_r[39:16];
        default:   value_r <= '0;
      endcase
    end
  end

  assign stat.below     = ffreq_r < binf_r;
  assign stat.not_above = freq_r <= ffreq_r;
  assign stat.freq_zero = freq_r == '0;
  assign value = value_r;
endmodule

@@ hw/rtl/lfbe_ctrl.sv @@
// Controller state machine sequencing commands over the datapath.
// Depends on lfbe_pkg.
module lfbe_ctrl
  import lfbe_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [1:0]      in_cmd,
  input  logic [12:0]     in_bin,
  input  logic [12:0]     half_size,
  input  lfbe_stat_t      stat,
  output lfbe_cmd_t       cmd,
  output logic [PtAW-1:0] rd_idx,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [2:0]      status,
  output logic [4:0]      stored_points
);
  localparam logic [3:0] SIdle = 4'd0, SApRd = 4'd1, SApWait = 4'd2, SApChk = 4'd3,
    SApWr = 4'd4, SEvRd = 4'd5, SEvWait = 4'd6, SEvChk = 4'd7, SLog = 4'd8,
    SDiv = 4'd9, SProd = 4'd10, SFin = 4'd11, SOut = 4'd12;
  localparam logic [4:0] DivSteps = 5'd17;

  logic [3:0] state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [CntW-1:0] idx_r, idx_nxt;
  logic [2:0] st_r, st_nxt;
  logic [4:0] dcnt_r, dcnt_nxt;
  logic [2:0] fsel_r, fsel_nxt;
  logic [12:0] hs;

  assign hs = (half_size > 13'(MaxHalfSize)) ? 13'(MaxHalfSize) : half_size;
  assign in_tready = state_r == SIdle;
  assign out_tvalid = state_r == SOut;
  assign status = st_r;
  assign stored_points = cnt_r;
  assign rd_idx = idx_r[PtAW-1:0];

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    st_nxt = st_r;
    fsel_nxt = fsel_r;
    dcnt_nxt = dcnt_r;
    cmd = '0;
    cmd.fin_sel = fsel_r;
    case (state_r)
      SIdle: if (in_tvalid) begin
        cmd.load = 1'b1;
        st_nxt = StOk;
        fsel_nxt = FinZero;
        idx_nxt = '0;
        case (in_cmd)
          CmdClear: begin cnt_nxt = '0; state_nxt = SFin; end
          CmdAppend: begin
            idx_nxt = (cnt_r == '0) ? '0 : cnt_r - 1'b1;
            state_nxt = SApRd;
          end
          CmdEval: begin
            if (cnt_r == '0) begin st_nxt = StEmpty; state_nxt = SFin; end
            else if (in_bin == 13'd0 || in_bin > hs) state_nxt = SFin;
            else state_nxt = SEvRd;
          end
          default: state_nxt = SFin;
        endcase
      end
      SApRd: state_nxt = SApWait;
      SApWait: begin cmd.scan = 1'b1; state_nxt = SApChk; end
      SApChk: begin
        state_nxt = SFin;
        if (stat.freq_zero) st_nxt = StZero;
        else if (cnt_r >= CntW'(MaxPoints)) st_nxt = StFull;
        else if (cnt_r != '0 && stat.not_above) st_nxt = StNotInc;
        else begin
          idx_nxt = cnt_r;
          state_nxt = SApWr;
        end
      end
      SApWr: begin
        cmd.wr = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        state_nxt = SFin;
      end
      SEvRd: state_nxt = SEvWait;
      SEvWait: begin cmd.scan = 1'b1; state_nxt = SEvChk; end
      SEvChk: begin
        if (!stat.below) begin
          if (idx_r == '0) begin fsel_nxt = FinFirst; state_nxt = SFin; end
          else begin fsel_nxt = FinInterp; state_nxt = SLog; end
        end else if (idx_r + 1'b1 >= cnt_r) begin
          fsel_nxt = FinLast;
          state_nxt = SFin;
        end else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = SEvRd;
        end
      end
      SLog: begin cmd.log_step = 1'b1; state_nxt = SDiv; end
      SDiv: begin
        dcnt_nxt = dcnt_r + 5'd1;
        if (dcnt_r == 5'd0) cmd.div_start = 1'b1;
        else cmd.div_step = 1'b1;
        if (dcnt_r == DivSteps) begin
          dcnt_nxt = '0;
          state_nxt = SProd;
        end
      end
      SProd: begin cmd.prod = 1'b1; state_nxt = SFin; end
      SFin: begin cmd.fin = 1'b1; state_nxt = SOut; end
      SOut: if (out_tready) state_nxt = SIdle;
      default: state_nxt = SIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SIdle;
      cnt_r <= '0;
      idx_r <= '0;
      st_r <= StOk;
      fsel_r <= FinZero;
      dcnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
      st_r <= st_nxt;
      fsel_r <= fsel_nxt;
      dcnt_r <= dcnt_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CntW'(MaxPoints))
    else $error("point count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(status) && $stable(stored_points))
    else $error("result lost under stall");
  assert property (@(posedge clk) disable iff (!rst_n) in_tready |-> !out_tvalid)
    else $error("input accepted while result pending");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> cnt_r < CntW'(MaxPoints))
    else $error("write into full contour");
endmodule

@@ hw/rtl/log_frequency_breakpoint_envelope.sv @@
// Top level of the log-frequency breakpoint envelope.
// Depends on lfbe_pkg, lfbe_ctrl, lfbe_datapath, lfbe_ram.
//
// Input stream in_*: tdata = {bin_index, point_gain, point_frequency}, tuser =
// command (0 clear, 1 append, 2 evaluate). One result per transaction on out_*:
// tdata = {stored_points, status, envelope_value}.
// Items are handled one at a time. Clear, unused command, empty contour and
// out-of-range bin go from the input transaction straight to SFin, which builds
// the result, and then to SOut, where out_tvalid is high. Append reads the last
// stored point (SApRd, SApWait, SApChk) and writes it in SApWr if stored.
// Evaluate passes SEvRd, SEvWait, SEvChk per breakpoint scanned and, when it
// interpolates, SLog, SDiv (serial divider) and SProd before SFin and SOut.
// in_tready is low while an item is in work or its result waits; a stalled
// receiver holds the result and the input side stalls behind it.
// Reset empties the contour and loads half_size 32 and bin_hop 11025.
// Registers via APB: half_size at 0x0, bin_hop at 0x4.
module log_frequency_breakpoint_envelope
  import lfbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,  // point_frequency, point_gain, bin_index
  input  logic [1:0]  in_tuser,  // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata, // envelope_value, status, stored_points
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [12:0] half_size_r;
  logic [19:0] bin_hop_r;
  lfbe_cmd_t cmd;
  lfbe_stat_t stat;
  logic [PtAW-1:0] rd_idx;
  logic [GainW-1:0] value;
  logic [2:0] status;
  logic [4:0] pts;

  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_size_r <= 13'd32;
      bin_hop_r <= 20'd11025;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr[2] == RegHalfSize) half_size_r <= cfg_pwdata[12:0];
      else bin_hop_r <= cfg_pwdata[19:0];
    end
  end
  assign cfg_prdata = cfg_paddr[2] ? {12'd0, bin_hop_r} : {19'd0, half_size_r};

  lfbe_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid,
    .in_tready, .in_cmd(in_tuser), .in_bin(in_tdata[60:48]), .half_size(half_size_r),
    .stat, .cmd, .rd_idx, .out_tvalid, .out_tready, .status, .stored_points(pts));

  lfbe_datapath u_dp (
    .clk, .cmd, .rd_idx, .in_freq(in_tdata[23:0]), .in_gain(in_tdata[47:24]),
    .in_bin(in_tdata[60:48]), .bin_hop(bin_hop_r), .stat, .value);

  assign out_tdata = {pts, status, value};
endmodule

@@ tb/log_frequency_breakpoint_envelope_test.sv @@
// Self-checking testbench for the log-frequency breakpoint envelope.
// Depends on lfbe_pkg and the log_frequency_breakpoint_envelope top level.
module log_frequency_breakpoint_envelope_test
  import lfbe_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPTS = MaxPoints;
  localparam int MAXHS = MaxHalfSize;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [4:0]  count;
    logic [2:0]  status;
    logic [23:0] value;
  } envelope_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [63:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  log_frequency_breakpoint_envelope uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [12:0] mdl_half_size;
  logic [19:0] mdl_bin_hop;
  logic [23:0] mdl_freq [NPTS];
  logic signed [23:0] mdl_gain [NPTS];
  int unsigned mdl_count;

  envelope_result_t expected_results[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned hold_off = 0;
  bit random_stall = 1'b0;

  function automatic logic [20:0] log2_mitchell(input logic [23:0] x);
    int k;
    logic [39:0] f;
    k = 0;
    for (int i = 0; i < 24; i++) if (x[i]) k = i;
    if (x == 0) return '0;
    f = ((40'(x) - (40'd1 << k)) << 16) >> k;
    return {5'(k), f[15:0]};
  endfunction

  function automatic envelope_result_t predict_envelope(input logic [1:0] cmd,
      input logic [23:0] pf, input logic signed [23:0] pg, input logic [12:0] bin);
    envelope_result_t r;
    int unsigned hs, below;
    logic [47:0] f64;
    logic [23:0] frq;
    logic [20:0] lo, hi, x;
    longint fr, prod;
    r = '0;
    if (cmd == CmdClear) begin
      mdl_count = 0;
    end else if (cmd == CmdAppend) begin
      if (pf == 0) r.status = StZero;
      else if (mdl_count >= NPTS) r.status = StFull;
      else if (mdl_count > 0 && pf <= mdl_freq[mdl_count-1]) r.status = StNotInc;
      else begin
        mdl_freq[mdl_count] = pf;
        mdl_gain[mdl_count] = pg;
        mdl_count++;
      end
    end else if (cmd == CmdEval) begin
      hs = (mdl_half_size < MAXHS) ? mdl_half_size : MAXHS;
      if (mdl_count == 0) r.status = StEmpty;
      else if (bin >= 1 && bin <= hs) begin
        f64 = 48'(bin) * 48'(mdl_bin_hop);
        frq = (f64 > 48'hFFFFFF) ? 24'hFFFFFF : f64[23:0];
        below = 0;
        while (below < mdl_count && mdl_freq[below] < frq) below++;
        if (below == 0) r.value = mdl_gain[0];
        else if (below >= mdl_count) r.value = mdl_gain[mdl_count-1];
        else begin
          lo = log2_mitchell(mdl_freq[below-1]);
          hi = log2_mitchell(mdl_freq[below]);
          x = log2_mitchell(frq);
          fr = 0;
          if (hi > lo && x > lo) begin
            fr = (longint'(x - lo) << 16) / longint'(hi - lo);
            if (fr > 65535) fr = 65535;
          end
          prod = fr * (longint'(mdl_gain[below]) - longint'(mdl_gain[below-1]));
          r.value = 24'(longint'(mdl_gain[below-1]) + (prod >>> 16));
        end
      end
    end
    r.count = 5'(mdl_count);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
      input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycles);
    mismatches++;
  endtask

  // result checker and receiver stall pattern
  always @(posedge clk) begin
    envelope_result_t got, want;
    cycles <= cycles + 1;
    if (out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_results.size() == 0) report_mismatch("unexpected result", out_tdata, 0);
      else begin
        want = expected_results.pop_front();
        if (got.value !== want.value)
          report_mismatch("envelope_value", 32'(got.value), 32'(want.value));
        if (got.status !== want.status)
          report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.count !== want.count)
          report_mismatch("stored_points", 32'(got.count), 32'(want.count));
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_tready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (random_stall) out_tready <= (($urandom & 7) < 5);
    else out_tready <= 1'b1;
  end

  always @(posedge clk) if (cycles > CYCLE_LIMIT) begin
    $display("end of test: mismatches");
    $finish;
  end

  task automatic send_item(input logic [1:0] cmd, input logic [23:0] pf,
      input logic [23:0] pg, input logic [12:0] bin);
    envelope_result_t exp_r;
    in_tdata <= {3'd0, bin, pg, pf};
    in_tuser <= cmd;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    exp_r = predict_envelope(cmd, pf, pg, bin);
    expected_results = {expected_results, exp_r};
    @(negedge clk);
    if (random_stall && ($urandom & 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= addr; cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    if (addr[2] == RegHalfSize) mdl_half_size = data[12:0];
    else mdl_bin_hop = data[19:0];
  endtask

  task automatic test_directed();
    send_item(CmdEval, 0, 0, 5);                  // empty contour
    send_item(CmdAppend, 0, 24'h123456, 0);       // zero frequency
    send_item(CmdAppend, 24'd100000, 24'h7FFFFF, 0);
    send_item(CmdAppend, 24'd100000, 0, 0);       // not increasing
    send_item(CmdAppend, 24'd50, 0, 0);
    send_item(CmdAppend, 24'd400000, 24'h800000, 0);
    send_item(CmdAppend, 24'hFFFFFF, 24'h010000, 0);
    send_item(CmdEval, 0, 0, 0);                  // bin 0
    send_item(CmdEval, 0, 0, 1);
    send_item(CmdEval, 0, 0, 16);
    send_item(CmdEval, 0, 0, 32);
    send_item(CmdEval, 0, 0, 33);                 // above half_size
    send_item(CmdEval, 0, 0, 13'h1FFF);
    send_item(CmdNone, 24'hFFFFFF, 24'hFFFFFF, 13'h1FFF);
    for (int i = 0; i < 14; i++) send_item(CmdAppend, 24'hFFFFF0 + 24'(i), 0, 0);
    send_item(CmdClear, 0, 0, 0);
    // fill the store, then one more
    for (int i = 0; i < 17; i++)
      send_item(CmdAppend, 24'(20000 * (i + 1)), 24'(i * 40000), 0);
    for (int i = 1; i < 33; i += 3) send_item(CmdEval, 0, 0, 13'(i));
    send_item(CmdClear, 0, 0, 0);
    drain();
  endtask

  task automatic test_config_extremes();
    write_reg({RegHalfSize, 2'b00}, 4096);
    write_reg({RegBinHop, 2'b00}, 20'hFFFFF);     // saturating bin frequency
    send_item(CmdAppend, 24'd1, 24'd7, 0);
    send_item(CmdAppend, 24'd2000000, 24'h7FFF00, 0);
    send_item(CmdEval, 0, 0, 4096);
    send_item(CmdEval, 0, 0, 1);
    send_item(CmdEval, 0, 0, 4097);
    drain();
    write_reg({RegHalfSize, 2'b00}, 1);
    write_reg({RegBinHop, 2'b00}, 1);
    send_item(CmdEval, 0, 0, 1);
    send_item(CmdEval, 0, 0, 2);
    send_item(CmdClear, 0, 0, 0);
    drain();
  endtask

  task automatic random_contour_phase(input int n_items);
    int unsigned npts, gap;
    logic [23:0] f;
    send_item(CmdClear, 0, 0, 0);
    npts = $urandom_range(1, 17);
    f = 0;
    for (int i = 0; i < npts; i++) begin
      gap = ($urandom & 1) ? $urandom_range(1, 4000) : $urandom_range(1, 2000000);
      f = (32'(f) + gap > 32'hFFFFFF) ? 24'hFFFFFF : f + 24'(gap);
      if (($urandom & 15) == 0)
        send_item(CmdAppend, ($urandom & 1) ? f : 24'd0, 24'($urandom), 0);
      else send_item(CmdAppend, f, 24'($urandom), 0);
    end
    for (int i = 0; i < n_items; i++) begin
      case ($urandom & 15)
        0: send_item(2'($urandom), 24'($urandom), 24'($urandom), 13'($urandom));
        1: send_item(CmdAppend, 24'($urandom), 24'($urandom), 0);
        default: send_item(CmdEval, 0, 0,
                           ($urandom & 7) ? 13'($urandom_range(0, mdl_half_size + 1))
                                          : 13'($urandom));
      endcase
    end
  endtask

  task automatic test_random();
    random_stall = 1'b1;
    for (int p = 0; p < 12; p++) begin
      drain();
      write_reg({RegHalfSize, 2'b00}, ($urandom & 1) ? $urandom_range(1, 64) : $urandom);
      write_reg({RegBinHop, 2'b00}, ($urandom & 1) ? $urandom_range(1, 40000) : $urandom);
      random_contour_phase(122);
    end
    drain();
  endtask

  task automatic test_backpressure();
    random_stall = 1'b0;
    hold_off = 400;   // receiver stalls while the sender keeps offering
    for (int i = 0; i < 20; i++) send_item(CmdEval, 0, 0, 13'($urandom_range(0, 40)));
    drain();
  endtask

  initial begin
    mdl_half_size = 13'd32;
    mdl_bin_hop = 20'd11025;
    mdl_count = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_config_extremes();
    test_random();
    test_backpressure();
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule

@@ sim.f @@
hw/rtl/lfbe_pkg.sv
hw/rtl/lfbe_ram.sv
hw/rtl/lfbe_datapath.sv
hw/rtl/lfbe_ctrl.sv
hw/rtl/log_frequency_breakpoint_envelope.sv
tb/log_frequency_breakpoint_envelope_test.sv
